/* src/archive_metadata_record_parser_macros.svh */
// assertion macros used by the archive metadata parser rtl
`ifndef ARCHIVE_METADATA_RECORD_PARSER_MACROS_SVH
`define ARCHIVE_METADATA_RECORD_PARSER_MACROS_SVH

// expression must hold at every clock edge out of reset
`define AMRP_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define AMRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/amrp_pkg.sv */
// types and constants of the archive metadata record parser
`default_nettype none

package amrp_pkg;

  localparam int SIZE_BITS = 32;

  localparam logic [31:0] HDR_MAGIC   = 32'h3141_4541;
  localparam logic [31:0] HDR_VERSION = 32'h0000_0001;

  // header byte positions that close a word
  localparam logic [3:0] HDR_MAGIC_LAST   = 4'd3;
  localparam logic [3:0] HDR_VERSION_LAST = 4'd7;
  localparam logic [3:0] HDR_SIZE_LAST    = 4'd11;

  localparam logic [1:0] LEN_LAST_BYTE = 2'd3;
  localparam logic [31:0] LEN_FIELD_BYTES = 32'd4;

  localparam logic [7:0] CHAR_NUL       = 8'h00;
  localparam logic [7:0] CHAR_QUOTE     = 8'h22;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_PRINT_LO  = 8'h20;
  localparam logic [7:0] CHAR_PRINT_HI  = 8'h7E;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_LENGTH = 3'd1,
    PH_NAME   = 3'd2,
    PH_VALUE  = 3'd3,
    PH_DONE   = 3'd4,
    PH_HALT   = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ROLE_HEADER = 3'd0,
    ROLE_LENGTH = 3'd1,
    ROLE_NAME   = 3'd2,
    ROLE_NUL    = 3'd3,
    ROLE_VALUE  = 3'd4,
    ROLE_BEYOND = 3'd5
  } role_t;

  typedef enum logic [3:0] {
    ERR_NONE      = 4'd0,
    ERR_HEADER    = 4'd1,
    ERR_NO_ROOM   = 4'd2,
    ERR_LEN_SHORT = 4'd3,
    ERR_OVERRUN   = 4'd4,
    ERR_UNTERM    = 4'd5,
    ERR_BAD_NAME  = 4'd6,
    ERR_BAD_VALUE = 4'd7,
    ERR_TRUNC     = 4'd8
  } err_t;

endpackage

`default_nettype wire

/* src/archive_metadata_record_parser.sv */
// archive metadata record parser: header check, record split, per-byte tagging
//
// usage:
//   s_* carries one archive byte per beat: tdata = data byte, tuser = start
//   of a new file (restarts parsing, clears the error), tlast = last byte.
//   m_* returns one beat per input beat with the byte, its role, the record
//   end mark in tlast, the json escape flag, the sticky error code and the
//   metadata done flag.
//   cfg_* writes check_printable (bit 0 of cfg_data); always ready. the user
//   must write it only while no beat is in flight; the block does not enforce it.
// timing:
//   the output beat is registered, in the cycle after its input beat; one
//   beat per cycle sustained while m_tready is high. the parse state and
//   the result are updated in the same edge from the incoming byte, through
//   one 32-bit compare and subtract level on the size and record counters.
// reset:
//   rst (synchronous) returns the parser to header phase with no error,
//   empties the output register and sets check_printable to 1.
// stall:
//   the output register is a single stage; s_tready drops only while it is
//   full and m_tready is low, and rises again in the cycle it is taken.
`default_nettype none

module archive_metadata_record_parser (
  input  wire         clk,
  input  wire         rst,
  // input beats
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // [7:0] data_byte
  input  wire         s_tuser,   // [0] file_start
  input  wire         s_tlast,   // file_end
  // result beats
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [15:0] m_tdata,   // [7:0] byte_out, [10:8] role, [14:11] error_code
  output logic [1:0]  m_tuser,   // [0] needs_escape, [1] metadata_done
  output logic        m_tlast,   // record_last
  // configuration
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire         cfg_data
);

  import amrp_pkg::*;

  // parse state
  phase_t      phase, phase_next;
  logic [3:0]  hdr_count, hdr_count_next;
  logic [23:0] asm_word, asm_word_next;     // last three bytes, oldest low
  logic [31:0] meta_left, meta_left_next;   // metadata bytes not yet seen
  logic [31:0] rec_left, rec_left_next;     // record bytes after the length
  logic [1:0]  len_count, len_count_next;
  err_t        sticky_error, sticky_error_next;
  logic        check_printable;

  // state as seen by this beat (file start clears it first)
  phase_t      cur_phase;
  logic [3:0]  cur_hdr;
  logic [23:0] cur_asm;
  logic [31:0] cur_meta;
  logic [31:0] cur_rec;
  logic [1:0]  cur_len;
  err_t        cur_err;

  logic        accept;
  logic [7:0]  b;
  logic [31:0] word;
  logic [31:0] avail;
  logic        len_done, len_short, len_over, is_quote, is_print, size_big;
  logic        raise;
  err_t        raise_code;

  // result fields
  role_t       role;
  logic        rec_last;
  logic        esc;

  assign accept    = s_tvalid && s_tready;
  assign s_tready  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;

  assign b = s_tdata;

  always_comb begin
    if (s_tuser) begin
      cur_phase = PH_HEADER;
      cur_hdr   = '0;
      cur_asm   = '0;
      cur_meta  = '0;
      cur_rec   = '0;
      cur_len   = '0;
      cur_err   = ERR_NONE;
    end else begin
      cur_phase = phase;
      cur_hdr   = hdr_count;
      cur_asm   = asm_word;
      cur_meta  = meta_left;
      cur_rec   = rec_left;
      cur_len   = len_count;
      cur_err   = sticky_error;
    end
  end

  // shared decode of the byte and the counters
  assign word      = {b, cur_asm};
  assign avail     = cur_meta + 32'd3;
  assign len_done  = (cur_len == LEN_LAST_BYTE);
  assign len_short = (word < LEN_FIELD_BYTES);
  assign len_over  = (word > avail);
  assign is_quote  = (b == CHAR_QUOTE) || (b == CHAR_BACKSLASH);
  assign is_print  = (b >= CHAR_PRINT_LO) && (b <= CHAR_PRINT_HI);
  assign size_big  = (SIZE_BITS < 32) && ((word >> SIZE_BITS) != 32'd0);

  // next state
  always_comb begin
    phase_next     = cur_phase;
    hdr_count_next = cur_hdr;
    asm_word_next  = cur_asm;
    meta_left_next = cur_meta;
    rec_left_next  = cur_rec;
    len_count_next = cur_len;
    raise          = 1'b0;
    raise_code     = ERR_NONE;

    unique case (cur_phase)
      PH_HEADER: begin
        asm_word_next  = word[31:8];
        hdr_count_next = cur_hdr + 4'd1;
        if (cur_hdr == HDR_MAGIC_LAST && word != HDR_MAGIC) begin
          raise      = 1'b1;
          raise_code = ERR_HEADER;
        end else if (cur_hdr == HDR_VERSION_LAST && word != HDR_VERSION) begin
          raise      = 1'b1;
          raise_code = ERR_HEADER;
        end else if (cur_hdr == HDR_SIZE_LAST) begin
          if (size_big) begin
            raise      = 1'b1;
            raise_code = ERR_HEADER;
          end else begin
            meta_left_next = word;
            len_count_next = '0;
            phase_next     = (word == 32'd0) ? PH_DONE : PH_LENGTH;
          end
        end
      end
      PH_LENGTH: begin
        if (cur_len == 2'd0 && cur_meta < LEN_FIELD_BYTES) begin
          raise      = 1'b1;
          raise_code = ERR_NO_ROOM;
        end else begin
          asm_word_next = word[31:8];
          if (len_done) begin
            if (len_short) begin
              raise      = 1'b1;
              raise_code = ERR_LEN_SHORT;
            end else if (len_over) begin
              raise      = 1'b1;
              raise_code = ERR_OVERRUN;
            end else begin
              rec_left_next = word - LEN_FIELD_BYTES;
              if (word == LEN_FIELD_BYTES) begin
                raise      = 1'b1;
                raise_code = ERR_UNTERM;
              end else begin
                phase_next = PH_NAME;
              end
            end
          end
          len_count_next = cur_len + 2'd1;
          meta_left_next = cur_meta - 32'd1;
        end
      end
      PH_NAME: begin
        meta_left_next = cur_meta - 32'd1;
        rec_left_next  = cur_rec - 32'd1;
        if (b == CHAR_NUL) begin
          if (cur_rec == 32'd1) begin
            len_count_next = '0;
            phase_next     = (cur_meta == 32'd1) ? PH_DONE : PH_LENGTH;
          end else begin
            phase_next = PH_VALUE;
          end
        end else if (cur_rec == 32'd1) begin
          raise      = 1'b1;
          raise_code = ERR_UNTERM;
        end else if (check_printable && !is_print) begin
          raise      = 1'b1;
          raise_code = ERR_BAD_NAME;
        end
      end
      PH_VALUE: begin
        meta_left_next = cur_meta - 32'd1;
        rec_left_next  = cur_rec - 32'd1;
        if (check_printable && !is_print) begin
          raise      = 1'b1;
          raise_code = ERR_BAD_VALUE;
        end else if (cur_rec == 32'd1) begin
          len_count_next = '0;
          phase_next     = (cur_meta == 32'd1) ? PH_DONE : PH_LENGTH;
        end
      end
      default: begin
      end
    endcase

    if (raise) begin
      phase_next = PH_HALT;
    end
    // end of file while header or metadata is still open
    if (s_tlast && !raise && phase_next != PH_DONE && phase_next != PH_HALT) begin
      raise      = 1'b1;
      raise_code = ERR_TRUNC;
      phase_next = PH_HALT;
    end

    sticky_error_next = (raise && cur_err == ERR_NONE) ? raise_code : cur_err;
  end

  // per-byte result fields
  always_comb begin
    role     = ROLE_BEYOND;
    rec_last = 1'b0;
    esc      = 1'b0;
    unique case (cur_phase)
      PH_HEADER: role = ROLE_HEADER;
      PH_LENGTH: begin
        role     = ROLE_LENGTH;
        rec_last = (cur_len != 2'd0 || cur_meta >= LEN_FIELD_BYTES) && len_done &&
                   !len_over && (word == LEN_FIELD_BYTES);
      end
      PH_NAME: begin
        role     = (b == CHAR_NUL) ? ROLE_NUL : ROLE_NAME;
        rec_last = (cur_rec == 32'd1);
        esc      = is_quote;
      end
      PH_VALUE: begin
        role     = ROLE_VALUE;
        rec_last = (cur_rec == 32'd1);
        esc      = is_quote;
      end
      default: begin
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      hdr_count    <= '0;
      asm_word     <= '0;
      meta_left    <= '0;
      rec_left     <= '0;
      len_count    <= '0;
      sticky_error <= ERR_NONE;
    end else if (accept) begin
      phase        <= phase_next;
      hdr_count    <= hdr_count_next;
      asm_word     <= asm_word_next;
      meta_left    <= meta_left_next;
      rec_left     <= rec_left_next;
      len_count    <= len_count_next;
      sticky_error <= sticky_error_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      check_printable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      check_printable <= cfg_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {1'b0, sticky_error_next, role, b};
      m_tuser <= {(phase_next == PH_DONE) && (sticky_error_next == ERR_NONE), esc};
      m_tlast <= rec_last;
    end
  end

`include "archive_metadata_record_parser_macros.svh"

  `AMRP_ASSERT_ALWAYS(a_halt_has_error, (phase == PH_HALT) == (sticky_error != ERR_NONE), "halt phase and sticky error disagree")
  `AMRP_ASSERT_ALWAYS(a_hdr_count_range, (phase != PH_HEADER) || (hdr_count <= HDR_SIZE_LAST), "header count past the size word")
  `AMRP_ASSERT_ALWAYS(a_header_no_meta, (phase != PH_HEADER) || (meta_left == 32'd0), "metadata count live during header")
  `AMRP_ASSERT_NEXT(a_accept_loads, accept, m_tvalid, "accepted beat did not reach the output register")

endmodule

`default_nettype wire

/* tb/sv/parse_result_checker.sv */
// predicts and checks the tagged byte stream of the archive metadata parser
module parse_result_checker (
  input  wire              clk,
  input  wire              rst,
  input  wire              s_tvalid,
  input  wire              s_tready,
  input  wire  [7:0]       s_tdata,
  input  wire              s_tuser,
  input  wire              s_tlast,
  input  wire              m_tvalid,
  input  wire              m_tready,
  input  wire  [15:0]      m_tdata,
  input  wire  [1:0]       m_tuser,
  input  wire              m_tlast,
  input  wire              cfg_valid,
  input  wire              cfg_ready,
  input  wire              cfg_data,
  output int unsigned      fail_count,
  output int unsigned      pending
);

  import amrp_pkg::*;

  localparam logic [63:0] SIZE_MASK = (64'd1 << SIZE_BITS) - 64'd1;

  typedef struct packed {
    logic [7:0] octet;
    role_t      role;
    logic       rec_last;
    logic       esc;
    err_t       err;
    logic       done;
  } tagged_byte_t;

  // parser state as the block should hold it
  phase_t      phase;
  logic [3:0]  hdr_cnt;
  logic [31:0] word;
  logic [31:0] md_size;
  logic [31:0] md_off;
  logic [31:0] rec_left;
  logic [1:0]  len_cnt;
  err_t        err;
  logic        chk_print = 1'b1;

  tagged_byte_t tagged_q[$];
  tagged_byte_t want;
  int unsigned  fails = 0;

  function automatic void clear_parse();
    phase    = PH_HEADER;
    hdr_cnt  = '0;
    word     = '0;
    md_size  = '0;
    md_off   = '0;
    rec_left = '0;
    len_cnt  = '0;
    err      = ERR_NONE;
  endfunction

  // first error sticks, parsing stops either way
  function automatic void flag_error(input err_t code);
    if (err == ERR_NONE) err = code;
    phase = PH_HALT;
  endfunction

  function automatic void close_record();
    len_cnt = '0;
    phase = (md_off == md_size) ? PH_DONE : PH_LENGTH;
  endfunction

  function automatic logic printable(input logic [7:0] b);
    return b >= CHAR_PRINT_LO && b <= CHAR_PRINT_HI;
  endfunction

  function automatic logic json_special(input logic [7:0] b);
    return b == CHAR_QUOTE || b == CHAR_BACKSLASH;
  endfunction

  function automatic tagged_byte_t tag_byte(input logic [7:0] b, input logic fs,
                                            input logic fe);
    tagged_byte_t r;
    logic [31:0]  rec_len;
    logic [31:0]  room;
    r.octet    = b;
    r.role     = ROLE_BEYOND;
    r.rec_last = 1'b0;
    r.esc      = 1'b0;
    if (fs) clear_parse();
    case (phase)
      PH_HEADER: begin
        r.role = ROLE_HEADER;
        word = {b, word[31:8]};
        if (hdr_cnt == HDR_MAGIC_LAST && word != HDR_MAGIC) begin
          flag_error(ERR_HEADER);
        end else if (hdr_cnt == HDR_VERSION_LAST && word != HDR_VERSION) begin
          flag_error(ERR_HEADER);
        end else if (hdr_cnt == HDR_SIZE_LAST) begin
          if ({32'd0, word} > SIZE_MASK) begin
            flag_error(ERR_HEADER);
          end else begin
            md_size = word;
            md_off  = '0;
            len_cnt = '0;
            phase   = (word == 32'd0) ? PH_DONE : PH_LENGTH;
          end
        end
        hdr_cnt = hdr_cnt + 4'd1;
      end
      PH_LENGTH: begin
        r.role = ROLE_LENGTH;
        if (len_cnt == 2'd0 && (md_size - md_off) < LEN_FIELD_BYTES) begin
          flag_error(ERR_NO_ROOM);
        end else begin
          word = {b, word[31:8]};
          if (len_cnt == LEN_LAST_BYTE) begin
            rec_len = word;
            room    = md_size - md_off + 32'd3;
            if (rec_len < LEN_FIELD_BYTES) begin
              flag_error(ERR_LEN_SHORT);
            end else if (rec_len > room) begin
              flag_error(ERR_OVERRUN);
            end else begin
              rec_left = rec_len - LEN_FIELD_BYTES;
              if (rec_left == 32'd0) begin
                r.rec_last = 1'b1;
                flag_error(ERR_UNTERM);
              end else begin
                phase = PH_NAME;
              end
            end
          end
          len_cnt = len_cnt + 2'd1;
          md_off  = md_off + 32'd1;
        end
      end
      PH_NAME: begin
        md_off     = md_off + 32'd1;
        rec_left   = rec_left - 32'd1;
        r.rec_last = (rec_left == 32'd0);
        if (b == CHAR_NUL) begin
          r.role = ROLE_NUL;
          if (r.rec_last) close_record();
          else phase = PH_VALUE;
        end else begin
          r.role = ROLE_NAME;
          r.esc  = json_special(b);
          // a name running into the record end wins over a bad name byte
          if (r.rec_last) flag_error(ERR_UNTERM);
          else if (chk_print && !printable(b)) flag_error(ERR_BAD_NAME);
        end
      end
      PH_VALUE: begin
        r.role     = ROLE_VALUE;
        md_off     = md_off + 32'd1;
        rec_left   = rec_left - 32'd1;
        r.rec_last = (rec_left == 32'd0);
        r.esc      = json_special(b);
        if (chk_print && !printable(b)) flag_error(ERR_BAD_VALUE);
        else if (r.rec_last) close_record();
      end
      default: ;
    endcase
    if (fe && phase <= PH_VALUE) flag_error(ERR_TRUNC);
    r.err  = err;
    r.done = (phase == PH_DONE && err == ERR_NONE);
    return r;
  endfunction

  task automatic compare_field(input string label, input int unsigned exp_val,
                               input int unsigned act_val);
    if (exp_val != act_val) begin
      fails++;
      $display("%0t %s: expected %0h, actual %0h", $time, label, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_parse();
      chk_print = 1'b1;
      tagged_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) chk_print = cfg_data;
      if (s_tvalid && s_tready) tagged_q.push_back(tag_byte(s_tdata, s_tuser, s_tlast));
      if (m_tvalid && m_tready) begin
        if (tagged_q.size() == 0) begin
          fails++;
          $display("%0t result beat: expected none, actual tdata %0h", $time, m_tdata);
        end else begin
          want = tagged_q.pop_front();
          compare_field("byte_out", want.octet, m_tdata[7:0]);
          compare_field("role", want.role, m_tdata[10:8]);
          compare_field("error_code", want.err, m_tdata[14:11]);
          compare_field("tdata pad", 0, m_tdata[15]);
          compare_field("needs_escape", want.esc, m_tuser[0]);
          compare_field("metadata_done", want.done, m_tuser[1]);
          compare_field("record_last", want.rec_last, m_tlast);
        end
      end
    end
    fail_count <= fails;
    pending    <= tagged_q.size();
  end

endmodule

/* tb/sv/tb_archive_metadata_record_parser.sv */
// stimulus and verdict for the archive metadata record parser
module tb_archive_metadata_record_parser;
  import amrp_pkg::*;

  // ways a generated archive can be broken
  typedef enum int {
    FLAW_NONE,
    FLAW_MAGIC,
    FLAW_VERSION,
    FLAW_SIZE,
    FLAW_LEN_SHORT,
    FLAW_LEN_FOUR,
    FLAW_NO_NUL,
    FLAW_ODD_BYTE,
    FLAW_TRUNC
  } flaw_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = 8'h00;   // [7:0] data_byte
  logic        s_tuser   = 1'b0;    // [0] file_start
  logic        s_tlast   = 1'b0;    // file_end
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [15:0] m_tdata;             // [7:0] byte_out, [10:8] role, [14:11] error_code, [15] zero
  logic [1:0]  m_tuser;             // [0] needs_escape, [1] metadata_done
  logic        m_tlast;             // record_last
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data  = 1'b0;    // check_printable

  int unsigned fail_count;
  int unsigned pending;

  // archive under construction: metadata body first, then the whole file
  logic [7:0] body_q[$];
  logic [7:0] archive_q[$];

  bit idle_on  = 1'b1;
  int sent     = 0;
  int stall_left = 0;

  archive_metadata_record_parser uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  parse_result_checker result_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #8000000;
    $display("Mismatches found");
    $finish;
  end

  // result side back-pressure: m_tready dropped in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 9);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // one input beat, with an optional gap in front; valid stays high after
  task automatic send_beat(input logic [7:0] b, input bit fs, input bit fe);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= fs;
    s_tlast  <= fe;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  // stop sending and wait until every tagged byte has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // register write only with the parser idle
  task automatic write_cfg(input bit value);
    drain();
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // little-endian word into the body or the file
  task automatic put_word(input logic [31:0] w, input bit to_body);
    for (int i = 0; i < 4; i++) begin
      if (to_body) body_q.push_back(w[8*i +: 8]);
      else archive_q.push_back(w[8*i +: 8]);
    end
  endtask

  // text bytes lean on the json specials and the printable edges
  function automatic logic [7:0] pick_text_byte();
    case ($urandom_range(0, 9))
      0: return CHAR_QUOTE;
      1: return CHAR_BACKSLASH;
      2: return $urandom_range(0, 1) ? CHAR_PRINT_LO : CHAR_PRINT_HI;
      default: return 8'($urandom_range(CHAR_PRINT_LO, CHAR_PRINT_HI));
    endcase
  endfunction

  task automatic emit_record(input flaw_t flaw);
    int nlen;
    int vlen;
    int odd_pos;
    nlen = $urandom_range(0, 5);
    vlen = $urandom_range(0, 6);
    case (flaw)
      FLAW_LEN_SHORT: put_word($urandom_range(0, 3), 1'b1);
      FLAW_LEN_FOUR:  put_word(LEN_FIELD_BYTES, 1'b1);
      FLAW_NO_NUL: begin
        // name fills the record; sometimes its last byte is also unprintable
        put_word(32'd5 + nlen, 1'b1);
        for (int i = 0; i < nlen; i++) body_q.push_back(pick_text_byte());
        body_q.push_back($urandom_range(0, 1) ? pick_text_byte() :
                         8'($urandom_range(1, 31)));
      end
      default: begin
        odd_pos = (flaw == FLAW_ODD_BYTE) ? $urandom_range(0, nlen + vlen) : -1;
        put_word(32'd5 + nlen + vlen, 1'b1);
        for (int i = 0; i < nlen; i++)
          body_q.push_back(i == odd_pos ? 8'($urandom_range(1, 255)) : pick_text_byte());
        body_q.push_back(CHAR_NUL);
        for (int i = 0; i < vlen; i++)
          body_q.push_back(nlen + i == odd_pos ? 8'($urandom_range(0, 255)) :
                           pick_text_byte());
      end
    endcase
  endtask

  task automatic build_archive(input flaw_t flaw);
    int nrec;
    int bad_rec;
    int tmp;
    int k;
    logic [31:0] md_bytes;
    body_q.delete();
    archive_q.delete();
    nrec = $urandom_range(1, 3);
    bad_rec = $urandom_range(0, nrec - 1);
    for (int r = 0; r < nrec; r++) emit_record(r == bad_rec ? flaw : FLAW_NONE);
    md_bytes = body_q.size();
    if (flaw == FLAW_SIZE) begin
      // wild sizes run into truncation, near misses into room and overrun checks
      if ($urandom_range(0, 3) == 0) begin
        md_bytes = $urandom();
      end else begin
        tmp = int'($urandom_range(0, 10)) - 5 + body_q.size();
        md_bytes = (tmp < 0) ? 32'd0 : tmp;
      end
    end
    put_word(HDR_MAGIC, 1'b0);
    put_word(HDR_VERSION, 1'b0);
    put_word(md_bytes, 1'b0);
    foreach (body_q[i]) archive_q.push_back(body_q[i]);
    // trailing bytes past the metadata
    repeat ($urandom_range(0, 2)) archive_q.push_back(8'($urandom_range(0, 255)));
    if (flaw == FLAW_MAGIC || flaw == FLAW_VERSION) begin
      k = (flaw == FLAW_MAGIC) ? $urandom_range(0, 3) : $urandom_range(4, 7);
      archive_q[k] = archive_q[k] ^ (8'd1 << $urandom_range(0, 7));
    end
    if (flaw == FLAW_TRUNC) begin
      tmp = $urandom_range(1, archive_q.size() - 1);
      while (archive_q.size() > tmp) void'(archive_q.pop_back());
    end
  endtask

  // file_end always on the final byte; file_start only when asked
  task automatic send_archive(input bit with_start);
    for (int i = 0; i < archive_q.size(); i++)
      send_beat(archive_q[i], with_start && i == 0, i == archive_q.size() - 1);
  endtask

  initial begin : stimulus
    int    r;
    flaw_t flaw;
    bit    chk_now;
    int    next_cfg;
    chk_now  = 1'b1;
    next_cfg = 150;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: wrong magic, then a byte after the error
    archive_q = '{8'h00, 8'hFF, 8'h41, 8'h31, 8'h7E};
    send_archive(1'b1);
    // directed: empty metadata finishes on the last header byte, extremes after
    archive_q.delete();
    put_word(HDR_MAGIC, 1'b0);
    put_word(HDR_VERSION, 1'b0);
    put_word(32'd0, 1'b0);
    archive_q.push_back(8'hFF);
    archive_q.push_back(8'h00);
    send_archive(1'b1);
    // directed: file ends inside the header
    archive_q = '{8'h41, 8'h45, 8'h41};
    send_archive(1'b1);

    // start the random part with checking off
    chk_now = 1'b0;
    write_cfg(chk_now);

    while (sent < 1200) begin
      // no idling in the final stretch; otherwise idling comes and goes
      if (sent > 1000) idle_on = 1'b0;
      else idle_on = ($urandom_range(0, 3) != 0);

      // toggle checking every so often, each time from an idle parser
      if (sent >= next_cfg) begin
        chk_now = ~chk_now;
        write_cfg(chk_now);
        next_cfg += 150;
      end

      r = $urandom_range(0, 99);
      if (r < 8) begin
        // noise: raw bytes with stray starts and ends
        repeat ($urandom_range(1, 12))
          send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                    $urandom_range(0, 7) == 0);
      end else begin
        flaw = (r < 55) ? FLAW_NONE : flaw_t'($urandom_range(1, 8));
        build_archive(flaw);
        // an occasional file without file_start just continues the stream
        send_archive($urandom_range(0, 19) != 0);
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
